/* sv/oriented_unit_square_overlap_assert.svh */
// Assertion macros for the square overlap pipeline
`ifndef ORIENTED_UNIT_SQUARE_OVERLAP_ASSERT_SVH
`define ORIENTED_UNIT_SQUARE_OVERLAP_ASSERT_SVH

`define OSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define OSQ_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* sv/osq_pkg.sv */
// Shared constants, types and helpers of the square overlap pipeline
package osq_pkg;

  localparam logic signed [63:0] CA = 64'sd1686629713;
  localparam logic signed [63:0] CB = 64'sd693598668;
  localparam logic signed [63:0] CC = 64'sd85569304;
  localparam logic signed [63:0] CD = 64'sd5026995;
  localparam logic signed [63:0] CE = 64'sd172272;
  localparam logic signed [63:0] Q30 = 64'sd1073741824;
  localparam logic [49:0] FAR_LIMIT = 50'd47453132;
  localparam logic [49:0] NEAR_LIMIT = 50'd16777216;
  localparam logic signed [50:0] HALF_Q33 = 51'sd4294967296;
  localparam int NUM_LANES = 8;

  typedef struct packed {
    logic hx_pos;
    logic hy_pos;
  } corner_t;

  typedef struct packed {
    logic far;
    logic near;
  } verdict_t;

  function automatic logic signed [63:0] div_pow2(input logic signed [63:0] p,
                                                  input int sh);
    logic signed [63:0] m;
    m = -p;
    if (p < 0) begin
      div_pow2 = -(m >>> sh);
    end else begin
      div_pow2 = p >>> sh;
    end
  endfunction

endpackage

/* sv/osq_sine.sv */
// Pipelined Q16 sine of a 16-bit binary angle, eight register stages
module osq_sine (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [17:0] sin_o
);

  logic [1:0]         quad;
  logic [14:0]        k;
  logic [15:0]        x_nxt;
  logic [15:0]        x_r [0:5];
  logic               neg_r [0:6];
  logic [30:0]        x2_r [0:3];
  logic signed [31:0] t_r [0:3];
  logic signed [63:0] prod_r;
  logic signed [17:0] sin_r;
  logic signed [63:0] p1, p2, p3, p4, s;
  logic signed [31:0] t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic [16:0]        v;
  logic signed [17:0] sin_nxt;

  assign quad  = angle[15:14];
  assign k     = quad[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign x_nxt = {k, 1'b0};

  always_comb begin
    p1 = osq_pkg::CE * $signed({33'd0, x2_r[0]});
    t0_nxt = 32'(-osq_pkg::CD + osq_pkg::div_pow2(p1, 30));
    p2 = 64'(t_r[0]) * $signed({33'd0, x2_r[1]});
    t1_nxt = 32'(osq_pkg::CC + osq_pkg::div_pow2(p2, 30));
    p3 = 64'(t_r[1]) * $signed({33'd0, x2_r[2]});
    t2_nxt = 32'(-osq_pkg::CB + osq_pkg::div_pow2(p3, 30));
    p4 = 64'(t_r[2]) * $signed({33'd0, x2_r[3]});
    t3_nxt = 32'(osq_pkg::CA + osq_pkg::div_pow2(p4, 30));
    s = osq_pkg::div_pow2(prod_r, 15);
    if (s < 0) begin
      s = '0;
    end
    if (s > osq_pkg::Q30) begin
      s = osq_pkg::Q30;
    end
    v = 17'((s + 64'sd8192) >>> 14);
    sin_nxt = neg_r[6] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= x_nxt;
    neg_r[0] <= quad[1];
    for (int i = 1; i < 6; i++) begin
      x_r[i] <= x_r[i-1];
    end
    for (int i = 1; i < 7; i++) begin
      neg_r[i] <= neg_r[i-1];
    end
    x2_r[0] <= 31'(32'(x_r[0]) * 32'(x_r[0]));
    for (int i = 1; i < 4; i++) begin
      x2_r[i] <= x2_r[i-1];
    end
    t_r[0] <= t0_nxt;
    t_r[1] <= t1_nxt;
    t_r[2] <= t2_nxt;
    t_r[3] <= t3_nxt;
    prod_r <= 64'(t_r[3]) * $signed({48'd0, x_r[5]});
    sin_r  <= sin_nxt;
  end

  assign sin_o = sin_r;

endmodule

/* sv/osq_lane.sv */
// One corner lane: place the corner, map it into the other frame, test the box
module osq_lane (
  input  logic               clk,
  input  osq_pkg::corner_t   corner,
  input  logic signed [30:0] dx_i,
  input  logic signed [30:0] dy_i,
  input  logic signed [17:0] so_i,
  input  logic signed [17:0] co_i,
  input  logic signed [17:0] ss_i,
  input  logic signed [17:0] cs_i,
  output logic               inside_o
);

  logic signed [31:0] co_e, so_e, hxc, hxs, hyc, hys;
  logic signed [31:0] px_nxt, py_nxt, px_r, py_r;
  logic signed [17:0] ss_r, cs_r;
  logic signed [49:0] cx_r, sy_r, cy_r, sx_r;
  logic signed [50:0] ix, iy;
  logic               inside_r;

  always_comb begin
    co_e = 32'(co_i);
    so_e = 32'(so_i);
    hxc = corner.hx_pos ? co_e : -co_e;
    hxs = corner.hx_pos ? so_e : -so_e;
    hyc = corner.hy_pos ? co_e : -co_e;
    hys = corner.hy_pos ? so_e : -so_e;
    px_nxt = 32'(dx_i) + hxc - hys;
    py_nxt = 32'(dy_i) + hxs + hyc;
    ix = 51'(cx_r) + 51'(sy_r);
    iy = 51'(cy_r) - 51'(sx_r);
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    ss_r <= ss_i;
    cs_r <= cs_i;
    cx_r <= 50'(cs_r) * 50'(px_r);
    sy_r <= 50'(ss_r) * 50'(py_r);
    cy_r <= 50'(cs_r) * 50'(py_r);
    sx_r <= 50'(ss_r) * 50'(px_r);
    inside_r <= (ix >= -osq_pkg::HALF_Q33) && (ix <= osq_pkg::HALF_Q33) &&
                (iy >= -osq_pkg::HALF_Q33) && (iy <= osq_pkg::HALF_Q33);
  end

  assign inside_o = inside_r;

endmodule

/* sv/osq_merge.sv */
// Merge of the lane hits with the distance verdict into the registered result
module osq_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  osq_pkg::verdict_t                  verdict,
  input  logic [osq_pkg::NUM_LANES-1:0]      hit_i,
  output logic                               out_valid,
  output logic                               out_overlaps
);

  logic valid_r, ovl_r, ovl_nxt;

  assign ovl_nxt = !verdict.far && (verdict.near || (|hit_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    ovl_r <= ovl_nxt;
  end

  assign out_valid    = valid_r;
  assign out_overlaps = ovl_r;

endmodule

/* sv/oriented_unit_square_overlap.sv */
// Top level of the oriented unit square overlap test
// out_valid rises once the pair has passed the input registers, sine pipelines, corner lanes and merge register.
// Throughput: one pair per cycle; busy stays low and the pipeline never stalls.
// Rate is set by the sine pipelines and eight corner lanes, all fully pipelined.
// Reset: synchronous rst_n clears the valid chain.
// The receiver cannot stall: out_valid marks each result for one cycle.
`include "oriented_unit_square_overlap_assert.svh"
module oriented_unit_square_overlap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_first_center_x,
  input  logic [23:0] in_first_center_y,
  input  logic [15:0] in_first_angle,
  input  logic [23:0] in_second_center_x,
  input  logic [23:0] in_second_center_y,
  input  logic [15:0] in_second_angle,
  output logic        out_valid,
  output logic        out_overlaps
);

  logic                      vld_r [0:11];
  logic signed [23:0]        ax_r, ay_r, bx_r, by_r;
  logic [15:0]               aa_r, ba_r;
  logic signed [24:0]        dx_d [0:7];
  logic signed [24:0]        dy_d [0:7];
  logic [48:0]               dxx_r, dyy_r;
  logic [49:0]               dsq;
  osq_pkg::verdict_t         verd_nxt;
  osq_pkg::verdict_t         verd_d [0:8];
  logic signed [17:0]        sa, ca, sb, cb;
  logic signed [25:0]        dxw, dyw;
  logic signed [30:0]        dxp, dyp, dxn, dyn;
  logic [osq_pkg::NUM_LANES-1:0] hit;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i < 12; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ax_r <= in_first_center_x;
      ay_r <= in_first_center_y;
      aa_r <= in_first_angle;
      bx_r <= in_second_center_x;
      by_r <= in_second_center_y;
      ba_r <= in_second_angle;
    end
  end

  assign dsq = 50'(dxx_r) + 50'(dyy_r);
  assign verd_nxt.far  = dsq > osq_pkg::FAR_LIMIT;
  assign verd_nxt.near = dsq < osq_pkg::NEAR_LIMIT;

  always_ff @(posedge clk) begin
    dx_d[0] <= 25'(bx_r) - 25'(ax_r);
    dy_d[0] <= 25'(by_r) - 25'(ay_r);
    for (int i = 1; i < 8; i++) begin
      dx_d[i] <= dx_d[i-1];
      dy_d[i] <= dy_d[i-1];
    end
    dxx_r <= 49'(50'(dx_d[0]) * 50'(dx_d[0]));
    dyy_r <= 49'(50'(dy_d[0]) * 50'(dy_d[0]));
    verd_d[0] <= verd_nxt;
    for (int i = 1; i < 9; i++) begin
      verd_d[i] <= verd_d[i-1];
    end
  end

  osq_sine u_sin_a (.clk(clk), .angle(aa_r), .sin_o(sa));
  osq_sine u_cos_a (.clk(clk), .angle(aa_r + 16'h4000), .sin_o(ca));
  osq_sine u_sin_b (.clk(clk), .angle(ba_r), .sin_o(sb));
  osq_sine u_cos_b (.clk(clk), .angle(ba_r + 16'h4000), .sin_o(cb));

  assign dxw = 26'(dx_d[7]);
  assign dyw = 26'(dy_d[7]);
  assign dxp = $signed({dxw, 5'b0});
  assign dyp = $signed({dyw, 5'b0});
  assign dxn = -dxp;
  assign dyn = -dyp;

  for (genvar g = 0; g < osq_pkg::NUM_LANES; g++) begin : g_lane
    osq_pkg::corner_t crn;
    assign crn.hx_pos = ((g % 4) == 1) || ((g % 4) == 2);
    assign crn.hy_pos = (g % 4) >= 2;
    if (g < 4) begin : g_ab
      osq_lane u_lane (
        .clk(clk), .corner(crn), .dx_i(dxn), .dy_i(dyn),
        .so_i(sa), .co_i(ca), .ss_i(sb), .cs_i(cb), .inside_o(hit[g])
      );
    end else begin : g_ba
      osq_lane u_lane (
        .clk(clk), .corner(crn), .dx_i(dxp), .dy_i(dyp),
        .so_i(sb), .co_i(cb), .ss_i(sa), .cs_i(ca), .inside_o(hit[g])
      );
    end
  end

  osq_merge u_merge (
    .clk(clk), .rst_n(rst_n), .valid_i(vld_r[11]), .verdict(verd_d[8]),
    .hit_i(hit), .out_valid(out_valid), .out_overlaps(out_overlaps)
  );

  `OSQ_ASSERT_DLY(a_latency, start, 13, out_valid, "transfer lost in pipeline")
  `OSQ_ASSERT_IMP(a_origin, out_valid, $past(start, 13), "result without transfer")
  `OSQ_ASSERT_IMP(a_flags, vld_r[3] && verd_d[0].near, !verd_d[0].far, "near and far")
  `OSQ_ASSERT_DLY(a_far_clear, vld_r[11] && verd_d[8].far, 1, !out_overlaps,
                  "far pair reported as overlapping")

endmodule

/* sim/tb_oriented_unit_square_overlap.sv */
// Testbench for the oriented unit square overlap block: directed and random pairs
`timescale 1ns / 1ps
module tb_oriented_unit_square_overlap;

  localparam longint FAR_SQ = 64'sd47453132;
  localparam longint NEAR_SQ = 64'sd16777216;
  localparam longint HALF_EDGE = 64'sd4294967296;
  localparam int LATENCY = 12;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_first_center_x = '0;
  logic [23:0] in_first_center_y = '0;
  logic [15:0] in_first_angle = '0;
  logic [23:0] in_second_center_x = '0;
  logic [23:0] in_second_center_y = '0;
  logic [15:0] in_second_angle = '0;
  logic out_valid;
  logic out_overlaps;

  bit overlap_expected[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  oriented_unit_square_overlap dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_center_x(in_first_center_x), .in_first_center_y(in_first_center_y),
    .in_first_angle(in_first_angle), .in_second_center_x(in_second_center_x),
    .in_second_center_y(in_second_center_y), .in_second_angle(in_second_angle),
    .out_valid(out_valid), .out_overlaps(out_overlaps)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint quarter_wave(longint r);
    longint x, x2, t, s;
    x = r * 2;
    x2 = x * x;
    t = 64'sd172272;
    t = -64'sd5026995 + (t * x2) / 64'sd1073741824;
    t = 64'sd85569304 + (t * x2) / 64'sd1073741824;
    t = -64'sd693598668 + (t * x2) / 64'sd1073741824;
    t = 64'sd1686629713 + (t * x2) / 64'sd1073741824;
    s = (t * x) / 64'sd32768;
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return (s + 8192) / 16384;
  endfunction

  function automatic longint sine_q16(logic [15:0] a);
    longint r, v;
    r = longint'(a[13:0]);
    v = quarter_wave(a[14] ? 16384 - r : r);
    return a[15] ? -v : v;
  endfunction

  function automatic bit corner_in_frame(longint dx, longint dy, longint so, longint co,
                                         longint ss, longint cs);
    longint hx, hy, px, py, ix, iy;
    for (int i = 0; i < 4; i++) begin
      hx = (i == 1 || i == 2) ? 1 : -1;
      hy = (i >= 2) ? 1 : -1;
      px = dx + hx * co - hy * so;
      py = dy + hx * so + hy * co;
      ix = cs * px + ss * py;
      iy = cs * py - ss * px;
      if (ix >= -HALF_EDGE && ix <= HALF_EDGE && iy >= -HALF_EDGE && iy <= HALF_EDGE)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit squares_overlap(logic [23:0] ax, logic [23:0] ay, logic [15:0] aa,
                                         logic [23:0] bx, logic [23:0] by, logic [15:0] ba);
    longint dx, dy, d, sa, ca, sb, cb;
    dx = longint'($signed(bx)) - longint'($signed(ax));
    dy = longint'($signed(by)) - longint'($signed(ay));
    d = dx * dx + dy * dy;
    if (d > FAR_SQ) return 1'b0;
    if (d < NEAR_SQ) return 1'b1;
    sa = sine_q16(aa);
    ca = sine_q16(aa + 16'd16384);
    sb = sine_q16(ba);
    cb = sine_q16(ba + 16'd16384);
    return corner_in_frame(-dx * 32, -dy * 32, sa, ca, sb, cb) ||
           corner_in_frame(dx * 32, dy * 32, sb, cb, sa, ca);
  endfunction

  task automatic send_pair(logic [23:0] ax, logic [23:0] ay, logic [15:0] aa,
                           logic [23:0] bx, logic [23:0] by, logic [15:0] ba);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_first_center_x = ax;
    in_first_center_y = ay;
    in_first_angle = aa;
    in_second_center_x = bx;
    in_second_center_y = by;
    in_second_angle = ba;
    start = 1'b1;
    do @(posedge clk); while (busy);
    overlap_expected.insert(overlap_expected.size(),
                            squares_overlap(ax, ay, aa, bx, by, ba));
    @(negedge clk);
  endtask

  task automatic test_distance_gates();
    send_pair(24'd0, 24'd0, 16'd0, 24'd0, 24'd0, 16'd0);
    send_pair(24'h800000, 24'h800000, 16'h8000, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
    send_pair(24'h7FFFFF, 24'd0, 16'd0, 24'h800000, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'd0, 24'd6888, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'd0, 24'd6889, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'd0, 24'd4095, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'h8000, -24'sd4095, 24'd0, 16'h7FFF);
  endtask

  task automatic test_edges_and_angles();
    send_pair(24'd0, 24'd0, 16'd0, 24'd4096, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'd0, 24'd4097, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'd0, 24'd4096, 24'd4096, 16'd0);
    send_pair(24'd0, 24'd0, 16'd8192, 24'd5000, 24'd0, 16'd0);
    send_pair(24'd0, 24'd0, 16'd8192, 24'd5000, 24'd0, 16'd8192);
    send_pair(24'd0, 24'd0, 16'd16384, 24'd4096, 24'd0, 16'hC000);
    send_pair(24'd0, 24'd0, 16'h8000, 24'd0, 24'd4300, 16'h7FFF);
    send_pair(24'd100, -24'sd200, 16'hE000, 24'd4400, 24'd3000, 16'h2000);
    send_pair(24'h7FF000, 24'h7FF000, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0001);
    send_pair(24'h800000, 24'h800000, 16'h4000, 24'h801200, 24'h800000, 16'h6000);
  endtask

  task automatic test_random_pairs(int count, int pct);
    logic [23:0] ax, ay;
    idle_pct = pct;
    repeat (count) begin
      ax = 24'($urandom);
      ay = 24'($urandom);
      if ($urandom_range(9) == 0)
        send_pair(ax, ay, 16'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
      else
        send_pair(ax, ay, 16'($urandom),
                  ax + 24'($signed($urandom_range(0, 14000)) - 7000),
                  ay + 24'($signed($urandom_range(0, 14000)) - 7000), 16'($urandom));
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (overlap_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0b", $time, out_overlaps);
        errors <= errors + 1;
      end else begin
        if (out_overlaps !== overlap_expected[0]) begin
          $display("%0t: overlaps mismatch, expected %0b, actual %0b",
                   $time, overlap_expected[0], out_overlaps);
          errors <= errors + 1;
        end
        void'(overlap_expected.pop_front());
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_distance_gates();
    test_edges_and_angles();
    test_random_pairs(160, 0);
    test_random_pairs(160, 60);
    test_random_pairs(160, 0);
    test_random_pairs(160, 8);
    start = 1'b0;
    wait (overlap_expected.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && overlap_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/osq_pkg.sv
sv/osq_sine.sv
sv/osq_lane.sv
sv/osq_merge.sv
sv/oriented_unit_square_overlap.sv
sim/tb_oriented_unit_square_overlap.sv
